/* src/sdsbr_pkg.sv */
// ---------------------------------------------------------------------------
// sdsbr_pkg: shared types and constants for the SD SPI block receive unit
// Operation, result kind, status and register codes, phase encoding and the
// byte-wide CRC-16 update.
// ---------------------------------------------------------------------------
package sdsbr_pkg;

    // input operation codes (carried on s_tuser)
    localparam logic OP_BEGIN = 1'b0;
    localparam logic OP_BYTE  = 1'b1;

    // result kind codes (carried on m_tuser)
    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // end-of-block status codes
    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_CRC_ERR = 2'd1;
    localparam logic [1:0] STATUS_TIMEOUT = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_START_TOKEN = 2'd0;
    localparam logic [1:0] REG_BLOCK_BYTES = 2'd1;
    localparam logic [1:0] REG_HUNT_LIMIT  = 2'd2;

    // register reset values
    localparam logic [7:0]  START_TOKEN_RST = 8'hFE;
    localparam logic [9:0]  BLOCK_BYTES_RST = 10'd512;
    localparam logic [16:0] HUNT_LIMIT_RST  = 17'd80000;

    // largest block the unit handles; sizes above it saturate
    localparam int unsigned MAX_BLOCK_BYTES = 512;
    localparam logic [12:0] MAX_BLOCK       = 13'(MAX_BLOCK_BYTES);

    // phase encoding
    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_HUNT   = 3'd1;
    localparam logic [2:0] PH_DATA   = 3'd2;
    localparam logic [2:0] PH_CRC_HI = 3'd3;
    localparam logic [2:0] PH_CRC_LO = 3'd4;

    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_INIT = 16'h0000;

    typedef logic [15:0] crc_t;

    // CRC-16 CCITT, MSB first, one byte per call
    function automatic crc_t crc16_byte(input crc_t crc_in, input logic [7:0] data);
        crc_t crc;
        crc = crc_in ^ {data, 8'h00};
        for (int k = 0; k < 8; k++)
        begin
            if (crc[15])
                crc = {crc[14:0], 1'b0} ^ CRC_POLY;
            else
                crc = {crc[14:0], 1'b0};
        end
        return crc;
    endfunction

endpackage

/* src/sd_spi_block_receive_unit.sv */
// ---------------------------------------------------------------------------
// sd_spi_block_receive_unit: receive side of an SD card SPI single-block read
// Hunts for the start token, forwards the block data bytes while running a
// CRC-16 over them, checks the card's CRC and reports an end-of-block status.
// ---------------------------------------------------------------------------
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+------------------------------------------
//  s_axis  | in  | s_tvalid/s_tready  | s_tuser operation, s_tdata rx_byte
//  m_axis  | out | m_tvalid/m_tready  | m_tuser kind, m_tdata data/index/status,
//          |     |                    | m_tlast last
//  cfg     | in  | cfg_valid/cfg_ready| cfg_index, cfg_data
//
//  One transaction per cycle while m_axis is not stalled; each item sits in the
//  input register and then moves to the result register, which drives m_axis.
//  The byte-wide CRC update sits between those two registers. Reset clears all
//  control state and loads the register defaults. A stall on m_axis holds the
//  result register; the input register keeps accepting items that give no
//  result, and otherwise waits.
//
module sd_spi_block_receive_unit
(
    input  logic        clk,
    input  logic        rst_n,
    // slave stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] rx_byte
    input  logic        s_tuser,    // [0] operation
    // master stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,    // [7:0] data_byte, [16:8] byte_index,
                                    // [18:17] status, [23:19] zero
    output logic        m_tuser,    // [0] kind
    output logic        m_tlast,    // last
    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [16:0] cfg_data
);
    import sdsbr_pkg::*;

    // configuration registers
    logic [7:0]  start_token_reg;
    logic [9:0]  block_bytes_reg;
    logic [16:0] hunt_limit_reg;

    // input register
    logic        in_valid_reg;
    logic        in_op_reg;
    logic [7:0]  in_byte_reg;

    // engine state
    logic [2:0]  phase_reg, phase_next;
    logic [9:0]  byte_count_reg, byte_count_next;
    logic [16:0] hunt_count_reg, hunt_count_next;
    crc_t        crc_reg, crc_next;
    logic [7:0]  crc_high_reg, crc_high_next;

    // result register
    logic        out_valid_reg;
    logic        out_kind_reg, out_kind_next;
    logic [7:0]  out_data_reg, out_data_next;
    logic [8:0]  out_index_reg, out_index_next;
    logic [1:0]  out_status_reg, out_status_next;
    logic        out_last_reg, out_last_next;

    logic        produce;
    logic        advance;
    logic        out_free;
    logic [9:0]  block_eff;
    logic [16:0] limit_eff;
    logic [16:0] hunt_inc;
    logic [9:0]  count_inc;

    assign cfg_ready = 1'b1;

    // write configuration registers; unknown indexes drop
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_token_reg <= START_TOKEN_RST;
            block_bytes_reg <= BLOCK_BYTES_RST;
            hunt_limit_reg  <= HUNT_LIMIT_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_START_TOKEN: start_token_reg <= cfg_data[7:0];
                REG_BLOCK_BYTES: block_bytes_reg <= cfg_data[9:0];
                REG_HUNT_LIMIT:  hunt_limit_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // effective block size and hunt limit
    always_comb
    begin
        block_eff = (block_bytes_reg == 10'd0) ? 10'd1 : block_bytes_reg;
        if ({3'b000, block_eff} > MAX_BLOCK)
            block_eff = MAX_BLOCK[9:0];
        limit_eff = (hunt_limit_reg == 17'd0) ? 17'd1 : hunt_limit_reg;
    end

    assign hunt_inc  = hunt_count_reg + 17'd1;
    assign count_inc = byte_count_reg + 10'd1;

    // process the registered item against the engine state
    always_comb
    begin
        phase_next      = phase_reg;
        byte_count_next = byte_count_reg;
        hunt_count_next = hunt_count_reg;
        crc_next        = crc_reg;
        crc_high_next   = crc_high_reg;
        produce         = 1'b0;
        out_kind_next   = KIND_DATA;
        out_data_next   = 8'd0;
        out_index_next  = 9'd0;
        out_status_next = STATUS_OK;
        out_last_next   = 1'b0;

        if (in_op_reg == OP_BEGIN)
        begin
            phase_next      = PH_HUNT;
            byte_count_next = 10'd0;
            hunt_count_next = 17'd0;
            crc_next        = CRC_INIT;
            crc_high_next   = 8'd0;
        end
        else
        begin
            unique case (phase_reg)
                PH_HUNT:
                begin
                    if (in_byte_reg == start_token_reg)
                    begin
                        phase_next      = PH_DATA;
                        byte_count_next = 10'd0;
                        crc_next        = CRC_INIT;
                    end
                    else
                    begin
                        hunt_count_next = hunt_inc;
                        if (hunt_inc >= limit_eff)
                        begin
                            phase_next      = PH_IDLE;
                            produce         = 1'b1;
                            out_kind_next   = KIND_STATUS;
                            out_status_next = STATUS_TIMEOUT;
                            out_last_next   = 1'b1;
                        end
                    end
                end
                PH_DATA:
                begin
                    produce         = 1'b1;
                    out_data_next   = in_byte_reg;
                    out_index_next  = byte_count_reg[8:0];
                    crc_next        = crc16_byte(crc_reg, in_byte_reg);
                    byte_count_next = count_inc;
                    if (count_inc == 10'd0 || count_inc >= block_eff)
                        phase_next = PH_CRC_HI;
                end
                PH_CRC_HI:
                begin
                    crc_high_next = in_byte_reg;
                    phase_next    = PH_CRC_LO;
                end
                PH_CRC_LO:
                begin
                    phase_next      = PH_IDLE;
                    produce         = 1'b1;
                    out_kind_next   = KIND_STATUS;
                    out_status_next = ({crc_high_reg, in_byte_reg} == crc_reg) ?
                                      STATUS_OK : STATUS_CRC_ERR;
                    out_last_next   = 1'b1;
                end
                default: ;
            endcase
        end
    end

    // handshake: the item advances unless its result would overwrite a stalled one
    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && (out_free || !produce);
    assign s_tready = !in_valid_reg || advance;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_op_reg   <= s_tuser;
            in_byte_reg <= s_tdata;
        end
    end

    // engine state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            byte_count_reg <= 10'd0;
            hunt_count_reg <= 17'd0;
            crc_reg        <= CRC_INIT;
            crc_high_reg   <= 8'd0;
        end
        else if (advance)
        begin
            phase_reg      <= phase_next;
            byte_count_reg <= byte_count_next;
            hunt_count_reg <= hunt_count_next;
            crc_reg        <= crc_next;
            crc_high_reg   <= crc_high_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= advance && produce;
    end

    always_ff @(posedge clk)
    begin
        if (advance && produce)
        begin
            out_kind_reg   <= out_kind_next;
            out_data_reg   <= out_data_next;
            out_index_reg  <= out_index_next;
            out_status_reg <= out_status_next;
            out_last_reg   <= out_last_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {5'b00000, out_status_reg, out_index_reg, out_data_reg};

endmodule

/* sim/sd_spi_block_receive_unit_tb.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sd_spi_block_receive_unit_tb: self-checking bench for the SD SPI block receiver
// Drives begin and byte transactions, keeps its own model of the token hunt,
// data, CRC-16 and status phases, and compares every result field by field.
// ---------------------------------------------------------------------------
module sd_spi_block_receive_unit_tb;

    import sdsbr_pkg::*;

    localparam int          CLK_HALF        = 4;
    localparam int          RESET_CYCLES    = 12;
    localparam int          SETTLE_CYCLES   = 8;
    localparam int          WATCHDOG_CYCLES = 2000;
    localparam int unsigned RANDOM_ITEMS    = 1850;
    localparam int unsigned PHASE_ITEMS     = 200;
    localparam logic [1:0]  REG_UNUSED      = 2'd3;

    typedef enum int {RX_STEADY, RX_CHOPPY, RX_LONG_STALLS} rx_mode_e;

    typedef struct packed
    {
        logic        kind;
        logic [7:0]  data_byte;
        logic [8:0]  byte_index;
        logic [1:0]  status;
        logic        last;
    } rx_result_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = 8'h00;
    logic        s_tuser   = OP_BEGIN;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [23:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = REG_START_TOKEN;
    logic [16:0] cfg_data  = '0;

    // register shadows
    logic [7:0]  tok_reg   = START_TOKEN_RST;
    logic [9:0]  blk_reg   = BLOCK_BYTES_RST;
    logic [16:0] hunt_reg  = HUNT_LIMIT_RST;

    // read engine shadow
    logic [2:0]  rd_phase  = PH_IDLE;
    logic [9:0]  rd_count  = '0;
    logic [16:0] rd_hunt   = '0;
    logic [15:0] rd_crc    = CRC_INIT;
    logic [7:0]  rd_crc_hi = '0;

    rx_result_t  expected_q[$];
    int          fail_count  = 0;
    int unsigned item_count  = 0;
    int          quiet_cycles = 0;
    int          burst_left  = 0;
    int          stall_left  = 0;
    bit          tx_bursty   = 1'b0;
    rx_mode_e    rx_mode     = RX_STEADY;

    sd_spi_block_receive_unit DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #CLK_HALF clk = ~clk;

    // CRC-16 CCITT, one data bit at a time, MSB first
    function automatic logic [15:0] crc16_step(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] crc;
        logic        fb;
        crc = crc_in;
        for (int i = 7; i >= 0; i--)
        begin
            fb  = crc[15] ^ b[i];
            crc = {crc[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
        end
        return crc;
    endfunction

    // block size as the engine applies it: zero means one, large values saturate
    function automatic int unsigned block_len();
        int unsigned n;
        n = blk_reg;
        if (n == 0)
            n = 1;
        if (n > MAX_BLOCK_BYTES)
            n = MAX_BLOCK_BYTES;
        return n;
    endfunction

    function automatic int unsigned hunt_lim();
        return (hunt_reg == 0) ? 1 : hunt_reg;
    endfunction

    // favor the byte extremes
    function automatic logic [7:0] pick_byte();
        int unsigned r;
        r = $urandom_range(0, 7);
        if (r == 0)
            return 8'h00;
        if (r == 1)
            return 8'hFF;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] non_token_byte();
        logic [7:0] b;
        b = pick_byte();
        if (b == tok_reg)
            b = b ^ 8'h01;
        return b;
    endfunction

    // advance the read engine shadow by one accepted item
    function automatic void predict_item(input logic op, input logic [7:0] b);
        rx_result_t r;
        r = '0;
        if (op == OP_BEGIN)
        begin
            rd_phase  = PH_HUNT;
            rd_count  = '0;
            rd_hunt   = '0;
            rd_crc    = CRC_INIT;
            rd_crc_hi = '0;
            return;
        end
        case (rd_phase)
            PH_HUNT:
            begin
                if (b == tok_reg)
                begin
                    rd_phase = PH_DATA;
                    rd_count = '0;
                    rd_crc   = CRC_INIT;
                end
                else
                begin
                    rd_hunt = rd_hunt + 17'd1;
                    if (rd_hunt >= hunt_lim())
                    begin
                        rd_phase = PH_IDLE;
                        r.kind   = KIND_STATUS;
                        r.status = STATUS_TIMEOUT;
                        r.last   = 1'b1;
                        expected_q.push_back(r);
                    end
                end
            end
            PH_DATA:
            begin
                r.kind       = KIND_DATA;
                r.data_byte  = b;
                r.byte_index = rd_count[8:0];
                r.status     = STATUS_OK;
                expected_q.push_back(r);
                rd_crc   = crc16_step(rd_crc, b);
                rd_count = rd_count + 10'd1;
                if (rd_count == 0 || rd_count >= block_len())
                    rd_phase = PH_CRC_HI;
            end
            PH_CRC_HI:
            begin
                rd_crc_hi = b;
                rd_phase  = PH_CRC_LO;
            end
            PH_CRC_LO:
            begin
                rd_phase = PH_IDLE;
                r.kind   = KIND_STATUS;
                r.status = ({rd_crc_hi, b} == rd_crc) ? STATUS_OK : STATUS_CRC_ERR;
                r.last   = 1'b1;
                expected_q.push_back(r);
            end
            default:
            begin
            end
        endcase
    endfunction

    // send one item; leave tvalid high unless a burst gap starts
    task automatic send_item(input logic op, input logic [7:0] b);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= b;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (op == OP_BEGIN || rd_phase != PH_IDLE)
            item_count++;
        predict_item(op, b);
        if (tx_bursty)
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 24);
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 8))
                    @(posedge clk);
            end
            else
                burst_left--;
        end
    endtask

    // hold the sender until every expected result has arrived
    task automatic settle_pipeline();
        s_tvalid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [16:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            REG_START_TOKEN: tok_reg  = value[7:0];
            REG_BLOCK_BYTES: blk_reg  = value[9:0];
            REG_HUNT_LIMIT:  hunt_reg = value;
            default:
            begin
            end
        endcase
        @(posedge clk);
    endtask

    task automatic configure(input logic [7:0] tok, input logic [9:0] blk,
                             input logic [16:0] hunt);
        settle_pipeline();
        write_reg(REG_START_TOKEN, {9'd0, tok});
        write_reg(REG_BLOCK_BYTES, {7'd0, blk});
        write_reg(REG_HUNT_LIMIT, hunt);
    endtask

    // block read: begin, hunt noise, token, data, card CRC (optionally with one bit flipped)
    task automatic send_block(input int unsigned noise_n, input bit corrupt);
        logic [15:0] crc;
        logic [7:0]  b;
        int unsigned len;
        len = block_len();
        crc = CRC_INIT;
        send_item(OP_BEGIN, pick_byte());
        repeat (noise_n)
            send_item(OP_BYTE, non_token_byte());
        send_item(OP_BYTE, tok_reg);
        repeat (len)
        begin
            b   = pick_byte();
            crc = crc16_step(crc, b);
            send_item(OP_BYTE, b);
        end
        if (corrupt)
            crc = crc ^ (16'h0001 << $urandom_range(0, 15));
        send_item(OP_BYTE, crc[15:8]);
        send_item(OP_BYTE, crc[7:0]);
    endtask

    // run the hunt into its limit, or abandon it when the limit is large
    task automatic send_timeout();
        int unsigned lim;
        lim = hunt_lim();
        send_item(OP_BEGIN, pick_byte());
        if (lim <= 48)
            repeat (lim)
                send_item(OP_BYTE, non_token_byte());
        else
            repeat ($urandom_range(1, 8))
                send_item(OP_BYTE, non_token_byte());
    endtask

    task automatic test_idle_and_defaults();
        send_item(OP_BYTE, 8'h5A);
        send_item(OP_BEGIN, 8'hFF);
        send_item(OP_BYTE, 8'h00);
        send_item(OP_BYTE, START_TOKEN_RST);
        send_item(OP_BYTE, 8'hFF);
        // begin in the middle of a block drops it silently
        send_item(OP_BEGIN, 8'h00);
    endtask

    task automatic test_minimum_sizes();
        // zero block size acts as one byte, zero hunt limit acts as one
        configure(8'h00, 10'd0, 17'd0);
        send_block(0, 1'b0);
        send_item(OP_BEGIN, 8'h00);
        send_item(OP_BYTE, 8'h01);
    endtask

    task automatic test_crc_mismatch();
        configure(8'hFF, 10'd2, 17'h1FFFF);
        send_block(1, 1'b1);
    endtask

    task automatic test_block_resize();
        configure(8'h3C, 10'h3FF, 17'd3);
        send_item(OP_BEGIN, 8'h00);
        send_item(OP_BYTE, 8'h3C);
        send_item(OP_BYTE, 8'h00);
        send_item(OP_BYTE, 8'hFF);
        // shrink the block below the bytes already seen: one more data byte
        settle_pipeline();
        write_reg(REG_BLOCK_BYTES, 17'd1);
        send_item(OP_BYTE, 8'h5A);
        send_item(OP_BYTE, rd_crc[15:8]);
        send_item(OP_BYTE, rd_crc[7:0]);
        // a write to an unmapped index must leave the hunt limit alone
        settle_pipeline();
        write_reg(REG_UNUSED, 17'h1FFFF);
        send_timeout();
    endtask

    task automatic test_random_traffic();
        int unsigned phase_no;
        int unsigned phase_start;
        int unsigned pick;
        int unsigned max_noise;
        logic [7:0]  tok;
        logic [9:0]  blk;
        logic [16:0] hunt;
        phase_no   = 0;
        item_count = 0;
        while (item_count < RANDOM_ITEMS)
        begin
            // pick a register setting for this phase, extremes on fixed phases
            if (phase_no == 0)
                tok = 8'h00;
            else if (phase_no == 4)
                tok = 8'hFF;
            else
                tok = 8'($urandom_range(0, 255));
            if (phase_no == 2)
                blk = $urandom_range(0, 1) ? 10'd512 : 10'($urandom_range(513, 1023));
            else if ($urandom_range(0, 9) == 0)
                blk = 10'd0;
            else
                blk = 10'($urandom_range(1, 20));
            if (phase_no == 1)
                hunt = 17'h1FFFF;
            else if (phase_no == 3)
                hunt = 17'd0;
            else if ($urandom_range(0, 3) == 0)
                hunt = 17'($urandom_range(13, 131071));
            else
                hunt = 17'($urandom_range(1, 12));
            rx_mode   = rx_mode_e'(phase_no % 3);
            tx_bursty = (phase_no % 4) != 0;
            configure(tok, blk, hunt);

            phase_start = item_count;
            while (item_count - phase_start < PHASE_ITEMS && item_count < RANDOM_ITEMS)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 65)
                begin
                    max_noise = (hunt_lim() > 4) ? 4 : hunt_lim() - 1;
                    send_block($urandom_range(0, max_noise), $urandom_range(0, 6) == 0);
                end
                else if (pick < 77)
                    send_timeout();
                else if (pick < 87)
                begin
                    // block cut short; the next begin drops it
                    send_item(OP_BEGIN, pick_byte());
                    send_item(OP_BYTE, tok_reg);
                    repeat ($urandom_range(0, block_len() - 1))
                        send_item(OP_BYTE, pick_byte());
                end
                else if (pick < 97)
                    repeat ($urandom_range(1, 6))
                        send_item(($urandom_range(0, 3) == 0) ? OP_BEGIN : OP_BYTE, pick_byte());
                else
                    settle_pipeline();
            end
            phase_no++;
        end
    endtask

    // receiver back-pressure
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end
        else
        begin
            case (rx_mode)
                RX_STEADY:
                    m_tready <= 1'b1;
                RX_CHOPPY:
                    m_tready <= ($urandom_range(0, 3) != 0);
                default:
                begin
                    if ($urandom_range(0, 9) == 0)
                    begin
                        stall_left <= $urandom_range(1, 15);
                        m_tready   <= 1'b0;
                    end
                    else
                        m_tready <= 1'b1;
                end
            endcase
        end
    end

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endfunction

    // compare each result transaction against the oldest expectation
    always @(posedge clk)
    begin
        rx_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_q.size() == 0)
            begin
                $error("result with no expectation: kind %0d, tdata 0x%06h, last %0d",
                       m_tuser, m_tdata, m_tlast);
                fail_count++;
            end
            else
            begin
                want = expected_q.pop_front();
                check_field("kind", want.kind, m_tuser);
                check_field("data_byte", want.data_byte, m_tdata[7:0]);
                check_field("byte_index", want.byte_index, m_tdata[16:8]);
                check_field("status", want.status, m_tdata[18:17]);
                check_field("tdata padding", 0, m_tdata[23:19]);
                check_field("last", want.last, m_tlast);
            end
        end
    end

    // end the run when no transaction moves for too long
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_CYCLES)
        begin
            $display("watchdog: no transaction for %0d cycles", quiet_cycles);
            $display("Test completed with failures");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        repeat (RESET_CYCLES)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_idle_and_defaults();
        test_minimum_sizes();
        test_crc_mismatch();
        test_block_resize();
        test_random_traffic();

        settle_pipeline();
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
